/* design/cao_pkg.sv */
// Package for the chaotic attractor oscillator: item types, Q.28 constants,
// saturation helpers and the micro-op program run by the shared arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
package cao_pkg;

	localparam int WORD_W = 54;
	localparam int POS_W  = 40;
	localparam int SMP_W  = 24;
	localparam int KNOB_W = 24;
	localparam int MAG_W  = 52;
	localparam int HALF_W = 26;
	localparam int ACC_W  = 104;
	localparam int FRAC_W = 28;
	localparam int PC_W   = 7;
	localparam int NUM_W  = 38;
	localparam int DIV_W  = 41;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [SMP_W-1:0]  sample_t;
	typedef logic [KNOB_W-1:0]        knob_t;

	typedef struct packed {
		sample_t fm_cv;
		sample_t warp_cv;
		logic    warp_patched;
	} in_item_t;

	typedef struct packed {
		sample_t out_x;
		sample_t out_y;
		sample_t out_z;
		logic    restarted;
	} out_item_t;

	typedef struct packed {
		logic [1:0] index;
		knob_t      value;
	} cfg_item_t;

	// register indexes
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_TUNE = 2'd1;
	localparam logic [1:0] REG_WARP = 2'd2;
	localparam logic [1:0] REG_AMP  = 2'd3;

	// attractor modes
	localparam logic [1:0] MODE_SPROTT    = 2'd0;
	localparam logic [1:0] MODE_HELMHOLTZ = 2'd1;
	localparam logic [1:0] MODE_HALVORSEN = 2'd2;
	localparam logic [1:0] MODE_TSUCS     = 2'd3;

	localparam word_t WMAX   = 54'sd4503599627370495;
	localparam pos_t  PMAX   = 40'sd549755813887;
	localparam pos_t  PMIN   = -40'sd549755813888;
	localparam word_t K_ONE  = 54'sd268435456;
	localparam word_t K0P1   = 54'sd26843546;
	localparam word_t K0P8   = 54'sd214748365;
	localparam word_t K0P5   = 54'sd134217728;
	localparam word_t K5P11  = 54'sd1371705180;
	localparam word_t K0P55  = 54'sd147639501;
	localparam word_t K0P03  = 54'sd8053064;
	localparam word_t K1P4   = 54'sd375809638;
	localparam word_t K0P833 = 54'sd223606735;
	localparam word_t K0P4   = 54'sd107374182;
	localparam word_t K0P05  = 54'sd13421773;
	localparam word_t K3     = 54'sd805306368;
	localparam word_t K4     = 54'sd1073741824;
	localparam word_t K20    = 54'sd5368709120;
	localparam word_t K40    = 54'sd10737418240;
	localparam word_t K45    = 54'sd12079595520;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_CLP,
		OP_MUL,
		OP_OUT,
		OP_END
	} op_t;

	typedef enum logic [4:0] {
		SRC_X, SRC_Y, SRC_Z, SRC_T0, SRC_T1, SRC_P, SRC_DT, SRC_W,
		SRC_ZERO, SRC_ONE, SRC_K0P1, SRC_K0P8, SRC_K0P5, SRC_K5P11, SRC_K0P55,
		SRC_K0P03, SRC_K1P4, SRC_K4, SRC_K40, SRC_K20, SRC_K0P833,
		SRC_AMP, SRC_GAIN, SRC_ZOFF
	} src_t;

	typedef enum logic [3:0] {
		D_X, D_Y, D_Z, D_T0, D_T1, D_P, D_HX, D_HY, D_HZ
	} dst_t;

	typedef struct packed {
		op_t  op;
		dst_t dst;
		src_t a;
		src_t b;
	} instr_t;

	localparam logic [PC_W-1:0] PC_SPROTT    = 7'd0;
	localparam logic [PC_W-1:0] PC_HELMHOLTZ = 7'd17;
	localparam logic [PC_W-1:0] PC_HALVORSEN = 7'd34;
	localparam logic [PC_W-1:0] PC_TSUCS     = 7'd66;
	localparam logic [PC_W-1:0] PC_OUTPUT    = 7'd88;

	function automatic instr_t mk(op_t op, dst_t dst, src_t a, src_t b);
		instr_t i;
		i.op  = op;
		i.dst = dst;
		i.a   = a;
		i.b   = b;
		return i;
	endfunction

	function automatic logic [PC_W-1:0] prog_start(logic [1:0] m);
		case (m)
			MODE_SPROTT:    return PC_SPROTT;
			MODE_HELMHOLTZ: return PC_HELMHOLTZ;
			MODE_HALVORSEN: return PC_HALVORSEN;
			default:        return PC_TSUCS;
		endcase
	endfunction

	// Micro-op program: one Euler step per mode, then the shared output scaling
	function automatic instr_t prog(logic [PC_W-1:0] pc);
		case (pc)
			// Sprott
			7'd0:  return mk(OP_ADD, D_P,  SRC_K0P1,   SRC_W);
			7'd1:  return mk(OP_MUL, D_T0, SRC_K0P8,   SRC_Y);
			7'd2:  return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd3:  return mk(OP_CLP, D_X,  SRC_X,      SRC_T0);
			7'd4:  return mk(OP_MUL, D_T0, SRC_Y,      SRC_Z);
			7'd5:  return mk(OP_SUB, D_T0, SRC_ZERO,   SRC_T0);
			7'd6:  return mk(OP_SUB, D_T0, SRC_T0,     SRC_X);
			7'd7:  return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd8:  return mk(OP_CLP, D_Y,  SRC_Y,      SRC_T0);
			7'd9:  return mk(OP_MUL, D_T0, SRC_K0P5,   SRC_Y);
			7'd10: return mk(OP_MUL, D_T0, SRC_T0,     SRC_Y);
			7'd11: return mk(OP_MUL, D_T1, SRC_P,      SRC_X);
			7'd12: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd13: return mk(OP_SUB, D_T0, SRC_T0,     SRC_ONE);
			7'd14: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd15: return mk(OP_CLP, D_Z,  SRC_Z,      SRC_T0);
			7'd16: return mk(OP_END, D_T0, SRC_ZERO,   SRC_ZERO);
			// Helmholtz
			7'd17: return mk(OP_SUB, D_T0, SRC_W,      SRC_K0P5);
			7'd18: return mk(OP_MUL, D_T0, SRC_T0,     SRC_K0P03);
			7'd19: return mk(OP_ADD, D_P,  SRC_T0,     SRC_K0P55);
			7'd20: return mk(OP_MUL, D_T0, SRC_DT,     SRC_Y);
			7'd21: return mk(OP_CLP, D_X,  SRC_X,      SRC_T0);
			7'd22: return mk(OP_MUL, D_T0, SRC_K5P11,  SRC_Z);
			7'd23: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd24: return mk(OP_CLP, D_Y,  SRC_Y,      SRC_T0);
			7'd25: return mk(OP_SUB, D_T0, SRC_ZERO,   SRC_Z);
			7'd26: return mk(OP_MUL, D_T1, SRC_P,      SRC_Y);
			7'd27: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd28: return mk(OP_SUB, D_T0, SRC_T0,     SRC_X);
			7'd29: return mk(OP_MUL, D_T1, SRC_X,      SRC_X);
			7'd30: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd31: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd32: return mk(OP_CLP, D_Z,  SRC_Z,      SRC_T0);
			7'd33: return mk(OP_END, D_T0, SRC_ZERO,   SRC_ZERO);
			// Halvorsen
			7'd34: return mk(OP_ADD, D_P,  SRC_K1P4,   SRC_W);
			7'd35: return mk(OP_MUL, D_T0, SRC_P,      SRC_X);
			7'd36: return mk(OP_SUB, D_T0, SRC_ZERO,   SRC_T0);
			7'd37: return mk(OP_MUL, D_T1, SRC_K4,     SRC_Y);
			7'd38: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd39: return mk(OP_MUL, D_T1, SRC_K4,     SRC_Z);
			7'd40: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd41: return mk(OP_MUL, D_T1, SRC_Y,      SRC_Y);
			7'd42: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd43: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd44: return mk(OP_CLP, D_X,  SRC_X,      SRC_T0);
			7'd45: return mk(OP_MUL, D_T0, SRC_P,      SRC_Y);
			7'd46: return mk(OP_SUB, D_T0, SRC_ZERO,   SRC_T0);
			7'd47: return mk(OP_MUL, D_T1, SRC_K4,     SRC_Z);
			7'd48: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd49: return mk(OP_MUL, D_T1, SRC_K4,     SRC_X);
			7'd50: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd51: return mk(OP_MUL, D_T1, SRC_Z,      SRC_Z);
			7'd52: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd53: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd54: return mk(OP_CLP, D_Y,  SRC_Y,      SRC_T0);
			7'd55: return mk(OP_MUL, D_T0, SRC_P,      SRC_Z);
			7'd56: return mk(OP_SUB, D_T0, SRC_ZERO,   SRC_T0);
			7'd57: return mk(OP_MUL, D_T1, SRC_K4,     SRC_X);
			7'd58: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd59: return mk(OP_MUL, D_T1, SRC_K4,     SRC_Y);
			7'd60: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd61: return mk(OP_MUL, D_T1, SRC_X,      SRC_X);
			7'd62: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd63: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd64: return mk(OP_CLP, D_Z,  SRC_Z,      SRC_T0);
			7'd65: return mk(OP_END, D_T0, SRC_ZERO,   SRC_ZERO);
			// TSUCS
			7'd66: return mk(OP_ADD, D_P,  SRC_W,      SRC_K0P55);
			7'd67: return mk(OP_SUB, D_T0, SRC_Y,      SRC_X);
			7'd68: return mk(OP_MUL, D_T0, SRC_K40,    SRC_T0);
			7'd69: return mk(OP_MUL, D_T1, SRC_K0P5,   SRC_X);
			7'd70: return mk(OP_MUL, D_T1, SRC_T1,     SRC_Z);
			7'd71: return mk(OP_ADD, D_T0, SRC_T0,     SRC_T1);
			7'd72: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd73: return mk(OP_CLP, D_X,  SRC_X,      SRC_T0);
			7'd74: return mk(OP_MUL, D_T0, SRC_K20,    SRC_Y);
			7'd75: return mk(OP_MUL, D_T1, SRC_X,      SRC_Z);
			7'd76: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd77: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd78: return mk(OP_CLP, D_Y,  SRC_Y,      SRC_T0);
			7'd79: return mk(OP_MUL, D_T0, SRC_K0P833, SRC_Z);
			7'd80: return mk(OP_MUL, D_T1, SRC_X,      SRC_Y);
			7'd81: return mk(OP_ADD, D_T0, SRC_T0,     SRC_T1);
			7'd82: return mk(OP_MUL, D_T1, SRC_P,      SRC_X);
			7'd83: return mk(OP_MUL, D_T1, SRC_T1,     SRC_X);
			7'd84: return mk(OP_SUB, D_T0, SRC_T0,     SRC_T1);
			7'd85: return mk(OP_MUL, D_T0, SRC_DT,     SRC_T0);
			7'd86: return mk(OP_CLP, D_Z,  SRC_Z,      SRC_T0);
			7'd87: return mk(OP_END, D_T0, SRC_ZERO,   SRC_ZERO);
			// output scaling
			7'd88: return mk(OP_MUL, D_T0, SRC_X,      SRC_AMP);
			7'd89: return mk(OP_MUL, D_T0, SRC_T0,     SRC_GAIN);
			7'd90: return mk(OP_OUT, D_HX, SRC_T0,     SRC_ZERO);
			7'd91: return mk(OP_MUL, D_T0, SRC_Y,      SRC_AMP);
			7'd92: return mk(OP_MUL, D_T0, SRC_T0,     SRC_GAIN);
			7'd93: return mk(OP_OUT, D_HY, SRC_T0,     SRC_ZERO);
			7'd94: return mk(OP_SUB, D_T1, SRC_Z,      SRC_ZOFF);
			7'd95: return mk(OP_MUL, D_T0, SRC_T1,     SRC_AMP);
			7'd96: return mk(OP_MUL, D_T0, SRC_T0,     SRC_GAIN);
			7'd97: return mk(OP_OUT, D_HZ, SRC_T0,     SRC_ZERO);
			default: return mk(OP_END, D_T0, SRC_ZERO, SRC_ZERO);
		endcase
	endfunction

	function automatic word_t gain_of(logic [1:0] m);
		case (m)
			MODE_SPROTT:    return K0P4;
			MODE_HELMHOLTZ: return K3;
			MODE_HALVORSEN: return K0P5;
			default:        return K0P05;
		endcase
	endfunction

	function automatic logic signed [10:0] rate_k(logic [1:0] m);
		case (m)
			MODE_SPROTT:    return 11'sd1000;
			MODE_HELMHOLTZ: return 11'sd1000;
			MODE_HALVORSEN: return 11'sd200;
			default:        return 11'sd40;
		endcase
	endfunction

	function automatic logic [3:0] rate_c(logic [1:0] m);
		case (m)
			MODE_SPROTT:    return 4'd1;
			MODE_HELMHOLTZ: return 4'd10;
			MODE_HALVORSEN: return 4'd10;
			default:        return 4'd1;
		endcase
	endfunction

	function automatic pos_t start_x(logic [1:0] m);
		return (m == MODE_TSUCS) ? pos_t'(K_ONE) : pos_t'(K0P1);
	endfunction

	function automatic pos_t start_yz(logic [1:0] m);
		case (m)
			MODE_TSUCS:     return pos_t'(K_ONE);
			MODE_HALVORSEN: return '0;
			default:        return pos_t'(K0P1);
		endcase
	endfunction

	// saturate a widened sum to the working range
	function automatic word_t wsat(logic signed [WORD_W:0] v);
		if (v > (WORD_W+1)'(WMAX)) begin
			return WMAX;
		end
		if (v < -((WORD_W+1)'(WMAX))) begin
			return -WMAX;
		end
		return v[WORD_W-1:0];
	endfunction

	// saturate a widened sum to the position range
	function automatic pos_t clamp_pos(logic signed [WORD_W:0] v);
		if (v > (WORD_W+1)'(PMAX)) begin
			return PMAX;
		end
		if (v < (WORD_W+1)'(PMIN)) begin
			return PMIN;
		end
		return v[POS_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] mag52(word_t v);
		word_t n;
		n = -v;
		return v[WORD_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	// floor shift by five, then saturate to a sample
	function automatic sample_t sat_out(word_t v);
		word_t s;
		s = v >>> 5;
		if (s > 54'sd8388607) begin
			return 24'sh7FFFFF;
		end
		if (s < -54'sd8388608) begin
			return 24'sh800000;
		end
		return s[SMP_W-1:0];
	endfunction

endpackage

/* design/cao_stream_if.sv */
// Valid/ready channel used for configuration, sample and result items.
// The payload type is set at instantiation; no package dependency.
`timescale 1ns / 1ps
interface cao_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/chaotic_attractor_oscillator_core.sv */
// Chaotic attractor oscillator core: one Euler step of the selected attractor per item.
// Depends on cao_pkg and cao_stream_if.
`timescale 1ns / 1ps
// Each accepted ctrl item advances the attractor selected by the mode register by one
// Euler step and yields one audio item (x, y, z scaled by amplitude and a per-mode gain).
// Everything runs on one shared 26x26 multiplier (four partial products, one multiply
// at a time) and one adder under a micro-op sequencer. Setup computes the step size as
// the numerator times a constant reciprocal of AUDIO_FS on the multiplier; a patched
// warp input adds a warp multiply to the setup. Of all steps, a Helmholtz step that ends
// in an overflow restart takes the least time from ctrl item to audio item, and a
// Halvorsen step with warp patched the most. ctrl is ready only between items: it rises
// at the earliest in the same cycle that the finished audio item turns valid. A
// finished audio item waits in its own register while the next item is taken.
// Configuration writes are taken at any time, but belong between items.
module chaotic_attractor_oscillator_core #(
	parameter int unsigned AUDIO_FS = 48000
) (
	input  logic         clk,
	input  logic         arst_n,
	cao_stream_if.sink   cfg,
	cao_stream_if.sink   ctrl,
	cao_stream_if.source audio
);
	import cao_pkg::*;

	// reciprocal of the rate, scaled by 2^DT_SH; exact for |num * 16| below 2^40
	localparam int DT_SH = 58;
	localparam logic [63:0] RECIP_L =
		((64'd1 << DT_SH) + 64'(AUDIO_FS) - 64'd1) / 64'(AUDIO_FS);
	localparam logic [MAG_W-1:0] RECIP = RECIP_L[MAG_W-1:0];

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUM,
		ST_DIV,
		ST_WARP,
		ST_EXEC,
		ST_MUL,
		ST_MFIN,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0] mode_q;
	knob_t      tune_q, warp_q, amp_q;

	// item and step state
	logic [2:0] last_mode_q;
	logic [1:0] m_q;
	sample_t    fm_q, cv_q;
	logic       patched_q;
	pos_t       x_q, y_q, z_q;
	word_t      t0_q, t1_q, p_q, dt_q, w_q;
	sample_t    hx_q, hy_q, hz_q;
	logic [PC_W-1:0] pc_q;
	logic       out_phase_q, restart_q;

	// step size numerator
	logic signed [NUM_W-1:0] num_q;
	logic [2:0]       cnt_q;

	// shared multiplier
	logic [MAG_W-1:0]  ma_q, mb_q;
	logic              mneg_q, mwarp_q, mdiv_q;
	dst_t              mdst_q;
	logic [MAG_W-1:0]  pp_q;
	logic [6:0]        sh_q;
	logic [ACC_W-1:0]  acc_q;

	// result register
	sample_t ox_q, oy_q, oz_q;
	logic    ores_q, ovalid_q;

	instr_t ins;
	word_t  opa, opb;

	function automatic word_t src_val(src_t s);
		case (s)
			SRC_X:      return word_t'(x_q);
			SRC_Y:      return word_t'(y_q);
			SRC_Z:      return word_t'(z_q);
			SRC_T0:     return t0_q;
			SRC_T1:     return t1_q;
			SRC_P:      return p_q;
			SRC_DT:     return dt_q;
			SRC_W:      return w_q;
			SRC_ONE:    return K_ONE;
			SRC_K0P1:   return K0P1;
			SRC_K0P8:   return K0P8;
			SRC_K0P5:   return K0P5;
			SRC_K5P11:  return K5P11;
			SRC_K0P55:  return K0P55;
			SRC_K0P03:  return K0P03;
			SRC_K1P4:   return K1P4;
			SRC_K4:     return K4;
			SRC_K40:    return K40;
			SRC_K20:    return K20;
			SRC_K0P833: return K0P833;
			SRC_AMP:    return word_t'({amp_q, 4'b0});
			SRC_GAIN:   return gain_of(m_q);
			SRC_ZOFF:   return (m_q == MODE_TSUCS) ? K45 : '0;
			default:    return '0;
		endcase
	endfunction

	// decode the current micro-op
	assign ins = prog(pc_q);
	assign opa = src_val(ins.a);
	assign opb = src_val(ins.b);

	logic signed [WORD_W:0] sum_c, diff_c;
	assign sum_c  = {opa[WORD_W-1], opa} + {opb[WORD_W-1], opb};
	assign diff_c = {opa[WORD_W-1], opa} - {opb[WORD_W-1], opb};

	// step size numerator: (tune + 2 fm) * K + C * 2^24
	logic signed [26:0] tt_c;
	logic signed [NUM_W-1:0] num_c;
	assign tt_c  = $signed({3'b0, tune_q}) + $signed({{2{fm_q[SMP_W-1]}}, fm_q, 1'b0});
	assign num_c = NUM_W'(tt_c) * NUM_W'(rate_k(m_q))
		+ $signed({{(NUM_W-28){1'b0}}, rate_c(m_q), 24'b0});

	// dividend: num * 16 and its negation
	logic signed [NUM_W+3:0] nd_c, ndn_c;
	assign nd_c  = {num_q, 4'b0};
	assign ndn_c = -nd_c;

	// quotient magnitude from the reciprocal product
	logic [WORD_W-1:0] quo_ext;
	assign quo_ext = WORD_W'(acc_q[ACC_W-1:DT_SH]);

	// multiplier partial product select
	logic [HALF_W-1:0] pa_c, pb_c;
	assign pa_c = cnt_q[0] ? ma_q[MAG_W-1:HALF_W] : ma_q[HALF_W-1:0];
	assign pb_c = cnt_q[1] ? mb_q[MAG_W-1:HALF_W] : mb_q[HALF_W-1:0];

	// multiplier result: truncate, saturate
	logic [ACC_W-FRAC_W-1:0] hi_c;
	word_t  r_c, rs_c, wv_c;
	logic   sticky_c;
	assign hi_c     = acc_q[ACC_W-1:FRAC_W];
	assign sticky_c = |acc_q[FRAC_W-1:0];
	assign r_c      = (hi_c > (ACC_W-FRAC_W)'(WMAX)) ? WMAX : word_t'(hi_c[MAG_W-1:0]);
	assign rs_c     = mneg_q ? -r_c : r_c;
	assign wv_c     = (m_q == MODE_SPROTT && cv_q[SMP_W-1]) ? -(r_c + word_t'(sticky_c)) : r_c;

	knob_t cvm_c;
	assign cvm_c = cv_q[SMP_W-1] ? knob_t'(-cv_q) : knob_t'(cv_q);

	logic restart_c;
	assign restart_c = (x_q == PMAX) && (y_q == PMAX) && (z_q == PMAX);

	assign cfg.ready    = 1'b1;
	assign ctrl.ready   = (state_q == ST_IDLE);
	assign audio.valid  = ovalid_q;
	assign audio.data   = {ox_q, oy_q, oz_q, ores_q};

	// sequencer, register file and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_SPROTT;
			tune_q      <= '0;
			warp_q      <= '0;
			amp_q       <= '1;
			last_mode_q <= 3'd4;
			x_q         <= pos_t'(K0P1);
			y_q         <= pos_t'(K0P1);
			z_q         <= pos_t'(K0P1);
			hx_q        <= '0;
			hy_q        <= '0;
			hz_q        <= '0;
			ovalid_q    <= 1'b0;
			pc_q        <= '0;
			out_phase_q <= 1'b0;
			restart_q   <= 1'b0;
			cnt_q       <= '0;
			mdiv_q      <= 1'b0;
		end else begin
			// take configuration writes
			if (cfg.valid) begin
				case (cfg.data.index)
					REG_MODE: mode_q <= cfg.data.value[1:0];
					REG_TUNE: tune_q <= cfg.data.value;
					REG_WARP: warp_q <= cfg.data.value;
					REG_AMP:  amp_q  <= cfg.data.value;
					default:  ;
				endcase
			end

			// drop the result once taken; the hand-over below refills it
			if (audio.ready && state_q != ST_DONE) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (ctrl.valid) begin
						fm_q      <= ctrl.data.fm_cv;
						cv_q      <= ctrl.data.warp_cv;
						patched_q <= ctrl.data.warp_patched;
						m_q       <= mode_q;
						if ({1'b0, mode_q} != last_mode_q) begin
							x_q         <= start_x(mode_q);
							y_q         <= start_yz(mode_q);
							z_q         <= start_yz(mode_q);
							last_mode_q <= {1'b0, mode_q};
						end
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					num_q   <= num_c;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// |num * 16| times the reciprocal, sign kept aside
					ma_q    <= MAG_W'(nd_c[NUM_W+3] ? ndn_c[DIV_W-1:0] : nd_c[DIV_W-1:0]);
					mb_q    <= RECIP;
					mneg_q  <= nd_c[NUM_W+3];
					mwarp_q <= 1'b0;
					mdiv_q  <= 1'b1;
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_WARP: begin
					if (!patched_q) begin
						w_q     <= (m_q == MODE_TSUCS) ? word_t'({warp_q, 1'b0})
							: word_t'({warp_q, 4'b0});
						pc_q    <= prog_start(m_q);
						state_q <= ST_EXEC;
					end else begin
						// knob * |cv| / 2^19 through the shared multiplier
						ma_q    <= MAG_W'({warp_q, 9'b0});
						mb_q    <= MAG_W'(cvm_c);
						mneg_q  <= 1'b0;
						mwarp_q <= 1'b1;
						mdst_q  <= D_T0;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
					out_phase_q <= 1'b0;
				end
				ST_EXEC: begin
					case (ins.op)
						OP_ADD, OP_SUB: begin
							case (ins.dst)
								D_T0:    t0_q <= wsat(ins.op == OP_ADD ? sum_c : diff_c);
								D_T1:    t1_q <= wsat(ins.op == OP_ADD ? sum_c : diff_c);
								default: p_q  <= wsat(ins.op == OP_ADD ? sum_c : diff_c);
							endcase
							pc_q <= pc_q + PC_W'(1);
						end
						OP_CLP: begin
							case (ins.dst)
								D_X:     x_q <= clamp_pos(sum_c);
								D_Y:     y_q <= clamp_pos(sum_c);
								default: z_q <= clamp_pos(sum_c);
							endcase
							pc_q <= pc_q + PC_W'(1);
						end
						OP_MUL: begin
							ma_q    <= mag52(opa);
							mb_q    <= mag52(opb);
							mneg_q  <= opa[WORD_W-1] ^ opb[WORD_W-1];
							mwarp_q <= 1'b0;
							mdst_q  <= ins.dst;
							acc_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_MUL;
						end
						OP_OUT: begin
							case (ins.dst)
								D_HX:    hx_q <= sat_out(opa);
								D_HY:    hy_q <= sat_out(opa);
								default: hz_q <= sat_out(opa);
							endcase
							pc_q <= pc_q + PC_W'(1);
						end
						default: begin
							// end of a program: check for overflow restart after the step
							if (out_phase_q) begin
								state_q <= ST_DONE;
							end else if (restart_c) begin
								x_q       <= start_x(m_q);
								y_q       <= start_yz(m_q);
								z_q       <= start_yz(m_q);
								restart_q <= 1'b1;
								state_q   <= ST_DONE;
							end else begin
								restart_q   <= 1'b0;
								out_phase_q <= 1'b1;
								pc_q        <= PC_OUTPUT;
							end
						end
					endcase
				end
				ST_MUL: begin
					// four partial products, each registered in pp_q before it is added into the accumulator
					if (cnt_q != 3'd4) begin
						pp_q <= pa_c * pb_c;
						sh_q <= cnt_q[0] && cnt_q[1] ? 7'd52
							: (cnt_q[0] || cnt_q[1]) ? 7'd26 : 7'd0;
					end
					if (cnt_q != 3'd0) begin
						acc_q <= acc_q + ({{(ACC_W-MAG_W){1'b0}}, pp_q} << sh_q);
					end
					if (cnt_q == 3'd4) begin
						state_q <= ST_MFIN;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_MFIN: begin
					if (mdiv_q) begin
						// step size, truncated toward zero
						dt_q    <= mneg_q ? -$signed(quo_ext) : $signed(quo_ext);
						mdiv_q  <= 1'b0;
						state_q <= ST_WARP;
					end else begin
						if (mwarp_q) begin
							w_q  <= (m_q == MODE_TSUCS) ? (wv_c >>> 3) : wv_c;
							pc_q <= prog_start(m_q);
						end else begin
							case (mdst_q)
								D_T0:    t0_q <= rs_c;
								D_T1:    t1_q <= rs_c;
								default: p_q  <= rs_c;
							endcase
							pc_q <= pc_q + PC_W'(1);
						end
						state_q <= ST_EXEC;
					end
				end
				ST_DONE: begin
					// hand over once the result register is free
					if (!ovalid_q || audio.ready) begin
						ox_q     <= hx_q;
						oy_q     <= hy_q;
						oz_q     <= hz_q;
						ores_q   <= restart_q;
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* tb/tb_chaotic_attractor_oscillator_core.sv */
// Testbench for chaotic_attractor_oscillator_core: drives sample items, predicts each
// Euler step in fixed point and checks every audio item. Depends on cao_pkg and
// cao_stream_if.
`timescale 1ns / 1ps
module tb_chaotic_attractor_oscillator_core;
	import cao_pkg::*;

	localparam longint RATE   = 48000;
	localparam longint W_LIM  = 64'sd4503599627370495;
	localparam longint P_HI   = 64'sd549755813887;
	localparam longint P_LO   = -64'sd549755813888;
	localparam longint Q_ONE  = 64'sd268435456;
	localparam longint Q_0P1  = 64'sd26843546;
	localparam longint Q_0P8  = 64'sd214748365;
	localparam longint Q_0P5  = 64'sd134217728;
	localparam longint Q_5P11 = 64'sd1371705180;
	localparam longint Q_0P55 = 64'sd147639501;
	localparam longint Q_0P03 = 64'sd8053064;
	localparam longint Q_1P4  = 64'sd375809638;
	localparam longint Q_0P833 = 64'sd223606735;
	localparam longint Q_0P4  = 64'sd107374182;
	localparam longint Q_0P05 = 64'sd13421773;
	localparam int     N_PHASES = 10;
	localparam int     PHASE_ITEMS = 82;
	localparam int     LONG_HOLD = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cao_stream_if #(.T(cfg_item_t)) cfg_ch();
	cao_stream_if #(.T(in_item_t))  ctrl_ch();
	cao_stream_if #(.T(out_item_t)) audio_ch();

	chaotic_attractor_oscillator_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch.sink),
		.ctrl(ctrl_ch.sink),
		.audio(audio_ch.source)
	);

	always #6 clk = ~clk;

	// shadow registers and attractor state
	logic [1:0] sh_mode;
	knob_t      sh_tune, sh_warp, sh_amp;
	longint     px, py, pz;
	int         prev_mode;
	sample_t    held [3];

	in_item_t   sample_queue[$];
	out_item_t  audio_expected[$];
	int         n_mismatch = 0;
	int         n_results = 0;
	logic       quiet = 1'b0;
	logic       hold_long = 1'b0;

	function automatic longint sat_w(longint v);
		if (v > W_LIM) return W_LIM;
		if (v < -W_LIM) return -W_LIM;
		return v;
	endfunction

	function automatic longint clip_pos(longint v);
		if (v > P_HI) return P_HI;
		if (v < P_LO) return P_LO;
		return v;
	endfunction

	// Q.28 product: truncate magnitude, then saturate
	function automatic longint qmul(longint a, longint b);
		logic neg;
		longint sa, sb;
		longint unsigned ma, mb, ah, al, bh, bl, r;
		neg = (a < 0) != (b < 0);
		sa = sat_w(a);
		sb = sat_w(b);
		ma = (sa < 0) ? -sa : sa;
		mb = (sb < 0) ? -sb : sb;
		ah = ma >> 28;
		al = ma & 64'hFFFFFFF;
		bh = mb >> 28;
		bl = mb & 64'hFFFFFFF;
		if (ah * bh > (W_LIM >> 28)) begin
			r = W_LIM;
		end else begin
			r = ((ah * bh) << 28) + ah * bl + al * bh + ((al * bl) >> 28);
			if (r > W_LIM) r = W_LIM;
		end
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic void load_start(logic [1:0] m);
		if (m == MODE_TSUCS) begin
			px = Q_ONE; py = Q_ONE; pz = Q_ONE;
		end else if (m == MODE_HALVORSEN) begin
			px = Q_0P1; py = 0; pz = 0;
		end else begin
			px = Q_0P1; py = Q_0P1; pz = Q_0P1;
		end
	endfunction

	function automatic sample_t scale_out(longint v, logic [1:0] m);
		longint g, o;
		case (m)
			MODE_SPROTT:    g = Q_0P4;
			MODE_HELMHOLTZ: g = 3 * Q_ONE;
			MODE_HALVORSEN: g = Q_0P5;
			default:        g = Q_0P05;
		endcase
		o = qmul(qmul(v, longint'(sh_amp) << 4), g) >>> 5;
		if (o > 8388607) o = 8388607;
		if (o < -8388608) o = -8388608;
		return sample_t'(o);
	endfunction

	// advance the attractor by one Euler step and return the audio item
	function automatic out_item_t euler_step(in_item_t it);
		out_item_t r;
		logic [1:0] m;
		longint fm, cv, kn, w, dt, k, c, d, x, y, z, p;
		m = sh_mode;
		fm = longint'(it.fm_cv);
		cv = longint'(it.warp_cv);
		kn = longint'(sh_warp);
		if (int'(m) != prev_mode) begin
			load_start(m);
			prev_mode = int'(m);
		end
		case (m)
			MODE_SPROTT:    begin k = 1000; c = 1;  end
			MODE_HELMHOLTZ: begin k = 1000; c = 10; end
			MODE_HALVORSEN: begin k = 200;  c = 10; end
			default:        begin k = 40;   c = 1;  end
		endcase
		dt = (((longint'(sh_tune) + 2 * fm) * k + c * (64'sd1 << 24)) * 16) / RATE;
		if (!it.warp_patched) w = kn << 4;
		else if (m == MODE_SPROTT) w = (kn * cv) >>> 19;
		else w = (kn * ((cv < 0) ? -cv : cv)) >>> 19;
		x = px; y = py; z = pz;
		case (m)
			MODE_SPROTT: begin
				p = sat_w(Q_0P1 + w);
				x = clip_pos(sat_w(x + qmul(dt, qmul(Q_0P8, y))));
				d = sat_w(-qmul(y, z) - x);
				y = clip_pos(sat_w(y + qmul(dt, d)));
				d = sat_w(sat_w(qmul(qmul(Q_0P5, y), y) - qmul(p, x)) - Q_ONE);
				z = clip_pos(sat_w(z + qmul(dt, d)));
			end
			MODE_HELMHOLTZ: begin
				p = sat_w(qmul(sat_w(w - Q_0P5), Q_0P03) + Q_0P55);
				x = clip_pos(sat_w(x + qmul(dt, y)));
				y = clip_pos(sat_w(y + qmul(dt, qmul(Q_5P11, z))));
				d = sat_w(sat_w(sat_w(-z - qmul(p, y)) - x) - qmul(x, x));
				z = clip_pos(sat_w(z + qmul(dt, d)));
			end
			MODE_HALVORSEN: begin
				p = sat_w(Q_1P4 + w);
				d = sat_w(sat_w(sat_w(-qmul(p, x) - qmul(4 * Q_ONE, y))
					- qmul(4 * Q_ONE, z)) - qmul(y, y));
				x = clip_pos(sat_w(x + qmul(dt, d)));
				d = sat_w(sat_w(sat_w(-qmul(p, y) - qmul(4 * Q_ONE, z))
					- qmul(4 * Q_ONE, x)) - qmul(z, z));
				y = clip_pos(sat_w(y + qmul(dt, d)));
				d = sat_w(sat_w(sat_w(-qmul(p, z) - qmul(4 * Q_ONE, x))
					- qmul(4 * Q_ONE, y)) - qmul(x, x));
				z = clip_pos(sat_w(z + qmul(dt, d)));
			end
			default: begin
				p = sat_w((w >>> 3) + Q_0P55);
				d = sat_w(qmul(40 * Q_ONE, sat_w(y - x)) + qmul(qmul(Q_0P5, x), z));
				x = clip_pos(sat_w(x + qmul(dt, d)));
				d = sat_w(qmul(20 * Q_ONE, y) - qmul(x, z));
				y = clip_pos(sat_w(y + qmul(dt, d)));
				d = sat_w(sat_w(qmul(Q_0P833, z) + qmul(x, y)) - qmul(qmul(p, x), x));
				z = clip_pos(sat_w(z + qmul(dt, d)));
			end
		endcase
		px = x; py = y; pz = z;
		if (x == P_HI && y == P_HI && z == P_HI) begin
			// overflow: restart and repeat the last outputs
			load_start(m);
			r.restarted = 1'b1;
		end else begin
			held[0] = scale_out(x, m);
			held[1] = scale_out(y, m);
			held[2] = scale_out((m == MODE_TSUCS) ? sat_w(z - 45 * Q_ONE) : z, m);
			r.restarted = 1'b0;
		end
		r.out_x = held[0];
		r.out_y = held[1];
		r.out_z = held[2];
		return r;
	endfunction

	// sample driver: predict on accept, then offer the next item or idle
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_ch.valid <= 1'b0;
			ctrl_ch.data  <= '0;
		end else begin
			if (ctrl_ch.valid && ctrl_ch.ready) begin
				audio_expected.push_back(euler_step(ctrl_ch.data));
			end
			if (!ctrl_ch.valid || ctrl_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					ctrl_ch.valid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					ctrl_ch.valid <= 1'b1;
					ctrl_ch.data  <= sample_queue.pop_front();
					if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 11);
				end else begin
					ctrl_ch.valid <= 1'b0;
				end
			end
		end
	end

	// audio monitor and receiver stalls
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_ch.ready <= 1'b0;
		end else begin
			if (audio_ch.valid && audio_ch.ready) begin
				n_results++;
				if (audio_expected.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10) $display("unexpected audio item %p", audio_ch.data);
				end else begin
					out_item_t e;
					e = audio_expected.pop_front();
					if (e.out_x !== audio_ch.data.out_x || e.out_y !== audio_ch.data.out_y ||
							e.out_z !== audio_ch.data.out_z ||
							e.restarted !== audio_ch.data.restarted) begin
						n_mismatch++;
						if (n_mismatch <= 10) begin
							$display("audio mismatch: expected x=%0d y=%0d z=%0d r=%0b, got x=%0d y=%0d z=%0d r=%0b",
								e.out_x, e.out_y, e.out_z, e.restarted, audio_ch.data.out_x,
								audio_ch.data.out_y, audio_ch.data.out_z, audio_ch.data.restarted);
						end
					end
				end
			end
			if (hold_long) begin
				audio_ch.ready <= 1'b0;
			end else if (quiet) begin
				audio_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				audio_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 10);
				audio_ch.ready <= 1'b0;
			end else begin
				audio_ch.ready <= 1'b1;
			end
		end
	end

	// long receiver hold while samples keep coming, to back up the core
	initial begin
		wait (n_results >= 150);
		@(posedge clk);
		hold_long <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_long <= 1'b0;
	end

	task automatic write_reg(logic [1:0] idx, knob_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, value: val};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_MODE: sh_mode = val[1:0];
			REG_TUNE: sh_tune = val;
			REG_WARP: sh_warp = val;
			default:  sh_amp  = val;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic knob_t pick_knob(int sel);
		case (sel)
			0:       return '0;
			1:       return '1;
			default: return knob_t'($urandom);
		endcase
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return 24'sh800000;
			1:       return 24'sh7FFFFF;
			2:       return '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic drain();
		while (sample_queue.size() > 0 || ctrl_ch.valid || audio_expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		sample_t fm_set [4];
		sample_t cv_set [3];
		in_item_t it;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		sh_mode = MODE_SPROTT;
		sh_tune = '0;
		sh_warp = '0;
		sh_amp  = '1;
		px = Q_0P1; py = Q_0P1; pz = Q_0P1;
		prev_mode = 4;
		held[0] = '0; held[1] = '0; held[2] = '0;
		repeat (11) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: field extremes on the reset settings
		fm_set = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'shFFFFFF};
		cv_set = '{24'sh800000, 24'sh7FFFFF, 24'sh000000};
		foreach (fm_set[i])
			foreach (cv_set[j]) begin
				it.fm_cv = fm_set[i];
				it.warp_cv = cv_set[j];
				it.warp_patched = 1'((i + j) % 2);
				sample_queue.push_back(it);
			end
		drain();

		// phases through every mode and knob extremes, with mode-change reloads
		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(REG_MODE, knob_t'((p < 8) ? p % 4 : $urandom_range(0, 3)));
			write_reg(REG_TUNE, pick_knob((p + 1) % 3));
			write_reg(REG_WARP, pick_knob(p % 3));
			write_reg(REG_AMP, pick_knob((p == 2) ? 0 : ((p + 2) % 3)));
			if (p == N_PHASES - 1) quiet <= 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it.fm_cv = pick_sample();
				it.warp_cv = pick_sample();
				it.warp_patched = 1'($urandom_range(0, 1));
				sample_queue.push_back(it);
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (n_mismatch == 0 && audio_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
